### sv/srt_pkg.sv
package srt_pkg;

    localparam int unsigned DefMaxRecords = 1024;

    localparam logic [1:0] OpClear  = 2'd0;
    localparam logic [1:0] OpAppend = 2'd1;
    localparam logic [1:0] OpRead   = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [43:0] key;
        logic [9:0]  score;
        logic [7:0]  group;
        logic [9:0]  position;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [43:0] out_key;
        logic [10:0] overall_rank;
        logic [7:0]  out_group;
        logic [10:0] group_rank;
        logic [10:0] record_total;
        logic        dropped;
    } t_out;

    typedef struct packed {
        logic [43:0] key;
        logic [9:0]  score;
        logic [7:0]  group;
    } t_rec;

endpackage

### sv/sort_and_rank_table.sv
// Sorted record table with competition ranking. Records are kept in memory in
// sorted order (score descending, key ascending, ties in arrival order), so an
// append walks down from the end of the table, moving each record that the new
// one beats up by one place, each step being a single memory read followed by a
// compare. A read of position p fetches entry p, then scans all N entries
// through the same port to count higher scores overall and within the group.
// Clear, ignored opcodes, reads past the end and appends to an empty or full
// table finish without leaving the idle state. One transfer is handled at a
// time; the result waits in an output register, and while it waits only a read
// is held off, since only a read needs that register.
module sort_and_rank_table
    import srt_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = DefMaxRecords
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
    localparam int unsigned WW = (CW > 10) ? CW : 10;

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StInsRd  = 3'd1;
    localparam logic [2:0] StInsCmp = 3'd2;
    localparam logic [2:0] StInsWr0 = 3'd3;
    localparam logic [2:0] StRdRd   = 3'd4;
    localparam logic [2:0] StRdCmp  = 3'd5;
    localparam logic [2:0] StScRd   = 3'd6;
    localparam logic [2:0] StScCmp  = 3'd7;

    t_rec r_mem [MAX_RECORDS];
    t_rec r_rdata;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_hg, n_hg;
    t_rec          r_new, n_new;
    t_rec          r_tgt, n_tgt;
    t_out          r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic          w_en;
    logic [AW-1:0] w_addr;
    t_rec          w_data;
    logic          new_first;
    logic          scan_last;

    assign o_ready = (r_state == StIdle)
        && (!r_ovalid || i_ready || (i_data.op != OpRead));
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[r_idx];
    end

    assign new_first = (r_new.score > r_rdata.score)
        || ((r_new.score == r_rdata.score) && (r_new.key < r_rdata.key));
    assign scan_last = (CW'(r_idx) + CW'(1)) == r_count;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_drop   = r_drop;
        n_hi     = r_hi;
        n_hg     = r_hg;
        n_new    = r_new;
        n_tgt    = r_tgt;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        w_en     = 1'b0;
        w_addr   = r_idx;
        w_data   = r_new;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            StIdle: begin
                if (i_valid && o_ready) begin
                    n_new.key   = i_data.key;
                    n_new.score = i_data.score;
                    n_new.group = i_data.group;
                    case (i_data.op)
                        OpClear: begin
                            n_count = '0;
                            n_drop  = 1'b0;
                        end
                        OpAppend: begin
                            if (r_count == CW'(MAX_RECORDS)) begin
                                n_drop = 1'b1;
                            end else if (r_count == '0) begin
                                w_en    = 1'b1;
                                w_addr  = '0;
                                w_data  = n_new;
                                n_count = CW'(1);
                            end else begin
                                n_idx   = AW'(r_count - CW'(1));
                                n_state = StInsRd;
                            end
                        end
                        OpRead: begin
                            if (WW'(i_data.position) < WW'(r_count)) begin
                                n_idx   = AW'(i_data.position);
                                n_state = StRdRd;
                            end else begin
                                n_out              = '0;
                                n_out.record_total = 11'(r_count);
                                n_out.dropped      = r_drop;
                                n_ovalid           = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            StInsRd: begin
                n_state = StInsCmp;
            end
            StInsCmp: begin
                w_en   = 1'b1;
                w_addr = r_idx + AW'(1);
                if (new_first) begin
                    // Move this record up one place and keep walking down.
                    w_data = r_rdata;
                    if (r_idx == '0) begin
                        n_state = StInsWr0;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = StInsRd;
                    end
                end else begin
                    w_data  = r_new;
                    n_count = r_count + CW'(1);
                    n_state = StIdle;
                end
            end
            StInsWr0: begin
                w_en    = 1'b1;
                w_addr  = '0;
                w_data  = r_new;
                n_count = r_count + CW'(1);
                n_state = StIdle;
            end
            StRdRd: begin
                n_state = StRdCmp;
            end
            StRdCmp: begin
                n_tgt   = r_rdata;
                n_idx   = '0;
                n_hi    = '0;
                n_hg    = '0;
                n_state = StScRd;
            end
            StScRd: begin
                n_state = StScCmp;
            end
            StScCmp: begin
                if (r_rdata.score > r_tgt.score) begin
                    n_hi = r_hi + CW'(1);
                    if (r_rdata.group == r_tgt.group) begin
                        n_hg = r_hg + CW'(1);
                    end
                end
                if (scan_last) begin
                    n_out.valid_res    = 1'b1;
                    n_out.out_key      = r_tgt.key;
                    n_out.overall_rank = 11'(n_hi + CW'(1));
                    n_out.out_group    = r_tgt.group;
                    n_out.group_rank   = 11'(n_hg + CW'(1));
                    n_out.record_total = 11'(r_count);
                    n_out.dropped      = r_drop;
                    n_ovalid           = 1'b1;
                    n_state            = StIdle;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = StScRd;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
        r_idx <= n_idx;
        r_hi  <= n_hi;
        r_hg  <= n_hg;
        r_new <= n_new;
        r_tgt <= n_tgt;
        r_out <= n_out;
    end

endmodule
